/* rtl/spq_pkg.sv */
package spq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int ID_W      = 8;
    localparam int TIME_W    = 16;
    localparam int WAIT_W    = 24;
    localparam int DELTA_W   = 16;
    localparam int CNT_OUT_W = 5;
    localparam int CMD_W     = 3;
    localparam int CFG_IDX_W = 1;
    localparam int KEY_W     = TIME_W + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 3'd0,
        CMD_POP_HEAD = 3'd1,
        CMD_POP_ARR  = 3'd2,
        CMD_ADD_WAIT = 3'd3,
        CMD_CLEAR    = 3'd4
    } cmd_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SORT_KEY   = 1'd0,
        REG_SORT_ORDER = 1'd1
    } cfg_reg_e;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WAIT = 1'b1
    } state_e;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [WAIT_W-1:0] waiting;
    } rec_t;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [ID_W-1:0]    proc_id;
        logic [TIME_W-1:0]  arrival;
        logic [TIME_W-1:0]  burst;
        logic [WAIT_W-1:0]  waiting_init;
        logic [DELTA_W-1:0] waiting_delta;
    } in_word_t;

    typedef struct packed {
        logic                 found;
        logic [ID_W-1:0]      out_id;
        logic [TIME_W-1:0]    out_arrival;
        logic [TIME_W-1:0]    out_burst;
        logic [WAIT_W-1:0]    out_waiting;
        logic [CNT_OUT_W-1:0] entry_count;
        logic                 is_empty;
        logic                 overflow;
        logic [TIME_W-1:0]    min_burst;
    } out_word_t;

    // broadcast to every cell
    typedef struct packed {
        logic               do_insert;
        logic               do_pop;
        logic               pop_head;
        logic               do_add;
        logic               sort_key;
        logic               sort_order;
        rec_t               new_rec;
        logic [TIME_W-1:0]  match_arr;
        logic [DELTA_W-1:0] delta;
    } ctl_t;

endpackage

/* rtl/sorted_process_queue.sv */
// Channel   Signals                                      Dir  Handshake
// command   start, busy, cmd (in_word_t)                 in   start & !busy
// result    done, result (out_word_t)                    out  done, one cycle, no stall
// config    cfg_valid, cfg_ready, cfg_index, cfg_data    in   cfg_valid & cfg_ready
//
// Every command runs from accept to done through the cell row and the min tree:
// the cell row updates at the accept edge, then the registered min tree over
// the burst times settles level by level. busy is high while the tree settles.
// Reset clears the fill count, the sort registers and the control state.
// Results cannot be stalled; cfg_ready is always high.
module sorted_process_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  spq_pkg::in_word_t                 cmd,
    output logic                              done,
    output spq_pkg::out_word_t                result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [spq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic                              cfg_data
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int LVL    = $clog2(DEPTH);
    localparam int LVL_W  = $clog2(LVL + 1);

    spq_pkg::state_e state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    logic             done_reg, done_next;
    logic             sort_key_reg, sort_order_reg;
    logic             found_reg, ovf_reg;
    spq_pkg::rec_t    pop_rec_reg;

    logic             accept;
    logic             full;
    logic             is_insert, is_pop_head, is_pop_arr, is_add, is_clear;
    spq_pkg::ctl_t    ctl;
    spq_pkg::rec_t    pop_rec;
    logic             found;

    spq_pkg::rec_t             rec_q    [DEPTH];
    logic [spq_pkg::KEY_W-1:0] key_q    [DEPTH];
    logic                      hit_q    [DEPTH];
    logic                      ins_c    [DEPTH+1];
    logic                      pop_c    [DEPTH+1];
    logic [spq_pkg::KEY_W-1:0] root;
    logic [31:0]               cnt_ext;

    assign accept = start && !busy;
    assign full   = count_reg == CNT_W'(DEPTH);

    assign is_insert   = cmd.command == spq_pkg::CMD_INSERT;
    assign is_pop_head = cmd.command == spq_pkg::CMD_POP_HEAD;
    assign is_pop_arr  = cmd.command == spq_pkg::CMD_POP_ARR;
    assign is_add      = cmd.command == spq_pkg::CMD_ADD_WAIT;
    assign is_clear    = cmd.command == spq_pkg::CMD_CLEAR;

    always_comb
    begin
        ctl.do_insert       = accept && is_insert && !full;
        ctl.do_pop          = accept && (is_pop_head || is_pop_arr);
        ctl.pop_head        = is_pop_head;
        ctl.do_add          = accept && is_add;
        ctl.sort_key        = sort_key_reg;
        ctl.sort_order      = sort_order_reg;
        ctl.new_rec.id      = cmd.proc_id;
        ctl.new_rec.arrival = cmd.arrival;
        ctl.new_rec.burst   = cmd.burst;
        ctl.new_rec.waiting = cmd.waiting_init;
        ctl.match_arr       = cmd.arrival;
        ctl.delta           = cmd.waiting_delta;
    end

    assign ins_c[0] = 1'b0;
    assign pop_c[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            spq_pkg::rec_t left_rec, right_rec;
            if (g == 0)
            begin : g_first
                assign left_rec = ctl.new_rec;
            end
            else
            begin : g_mid_l
                assign left_rec = rec_q[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_last
                assign right_rec = rec_q[g];
            end
            else
            begin : g_mid_r
                assign right_rec = rec_q[g+1];
            end

            spq_cell #(
                .IDX   (g),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .count     (count_reg),
                .left_rec  (left_rec),
                .right_rec (right_rec),
                .ins_in    (ins_c[g]),
                .ins_out   (ins_c[g+1]),
                .pop_in    (pop_c[g]),
                .pop_out   (pop_c[g+1]),
                .pop_hit   (hit_q[g]),
                .rec       (rec_q[g]),
                .min_key   (key_q[g])
            );
        end
    endgenerate

    spq_min_tree #(
        .DEPTH (DEPTH)
    ) u_min_tree (
        .clk  (clk),
        .leaf (key_q),
        .root (root)
    );

    assign found = pop_c[DEPTH];

    // at most one cell flags the first match
    always_comb
    begin
        pop_rec = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (hit_q[i])
                pop_rec = spq_pkg::rec_t'(pop_rec | rec_q[i]);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (ctl.do_insert)
                count_next = count_reg + CNT_W'(1);
            else if (ctl.do_pop && found)
                count_next = count_reg - CNT_W'(1);
            else if (is_clear)
                count_next = '0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        lvl_next   = lvl_reg;
        unique case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = spq_pkg::ST_WAIT;
                    lvl_next   = '0;
                end
            end
            spq_pkg::ST_WAIT:
            begin
                if (lvl_reg == LVL_W'(LVL - 1))
                    state_next = spq_pkg::ST_IDLE;
                else
                    lvl_next = lvl_reg + LVL_W'(1);
            end
            default:
            begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy      = 1'b0;
        done_next = 1'b0;
        unique case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                busy = 1'b0;
            end
            spq_pkg::ST_WAIT:
            begin
                busy      = 1'b1;
                done_next = lvl_reg == LVL_W'(LVL - 1);
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= spq_pkg::ST_IDLE;
            lvl_reg        <= '0;
            done_reg       <= 1'b0;
            count_reg      <= '0;
            sort_key_reg   <= 1'b0;
            sort_order_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lvl_reg   <= lvl_next;
            done_reg  <= done_next;
            count_reg <= count_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    spq_pkg::REG_SORT_KEY:   sort_key_reg   <= cfg_data;
                    spq_pkg::REG_SORT_ORDER: sort_order_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            found_reg   <= ctl.do_pop && found;
            pop_rec_reg <= (ctl.do_pop && found) ? pop_rec : '0;
            ovf_reg     <= is_insert && full;
        end
    end

    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign cnt_ext   = 32'(count_reg);

    always_comb
    begin
        result.found       = found_reg;
        result.out_id      = pop_rec_reg.id;
        result.out_arrival = pop_rec_reg.arrival;
        result.out_burst   = pop_rec_reg.burst;
        result.out_waiting = pop_rec_reg.waiting;
        result.entry_count = cnt_ext[spq_pkg::CNT_OUT_W-1:0];
        result.is_empty    = count_reg == '0;
        result.overflow    = ovf_reg;
        result.min_burst   = root[spq_pkg::KEY_W-1] ? '0 : root[spq_pkg::TIME_W-1:0];
    end

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("no busy after accepted word");

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result word without a command in flight");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.do_insert |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the queue");

    a_empty_min: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.is_empty |-> result.min_burst == '0)
        else $error("min burst nonzero on empty queue");
`endif

endmodule

/* rtl/spq_cell.sv */
module spq_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                       clk,
    input  spq_pkg::ctl_t              ctl,
    input  logic [CNT_W-1:0]           count,
    input  spq_pkg::rec_t              left_rec,
    input  spq_pkg::rec_t              right_rec,
    input  logic                       ins_in,
    output logic                       ins_out,
    input  logic                       pop_in,
    output logic                       pop_out,
    output logic                       pop_hit,
    output spq_pkg::rec_t              rec,
    output logic [spq_pkg::KEY_W-1:0]  min_key
);

    spq_pkg::rec_t             rec_reg;
    spq_pkg::rec_t             rec_next;
    logic                      occ;
    logic [spq_pkg::TIME_W-1:0] k_own;
    logic [spq_pkg::TIME_W-1:0] k_new;
    logic                      passes;
    logic                      ins_here;
    logic                      match;
    logic [spq_pkg::WAIT_W:0]  wsum;

    assign occ   = count > CNT_W'(IDX);
    assign k_own = ctl.sort_key ? rec_reg.arrival : rec_reg.burst;
    assign k_new = ctl.sort_key ? ctl.new_rec.arrival : ctl.new_rec.burst;

    // new record goes before the first held record that sorts after it,
    // or into the first free slot; equal keys keep arrival order
    assign passes   = ctl.sort_order ? (k_own < k_new) : (k_own > k_new);
    assign ins_here = !occ || passes;
    assign ins_out  = ins_in | ins_here;

    assign match   = occ && (ctl.pop_head ? (IDX == 0) : (rec_reg.arrival == ctl.match_arr));
    assign pop_out = pop_in | match;
    assign pop_hit = match && !pop_in;

    assign wsum = {1'b0, rec_reg.waiting} + (spq_pkg::WAIT_W + 1)'(ctl.delta);

    always_comb
    begin
        rec_next = rec_reg;
        if (ctl.do_insert)
        begin
            if (ins_in)
                rec_next = left_rec;
            else if (ins_here)
                rec_next = ctl.new_rec;
        end
        else if (ctl.do_pop)
        begin
            if (pop_out)
                rec_next = right_rec;
        end
        else if (ctl.do_add && occ)
        begin
            rec_next.waiting = wsum[spq_pkg::WAIT_W] ? {spq_pkg::WAIT_W{1'b1}}
                                                     : wsum[spq_pkg::WAIT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign rec     = rec_reg;
    // free slots sort above every real burst time
    assign min_key = occ ? {1'b0, rec_reg.burst} : {spq_pkg::KEY_W{1'b1}};

endmodule

/* rtl/spq_min_tree.sv */
module spq_min_tree #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic                      clk,
    input  logic [spq_pkg::KEY_W-1:0] leaf [DEPTH],
    output logic [spq_pkg::KEY_W-1:0] root
);

    localparam int LVL = $clog2(DEPTH);
    localparam int P   = 1 << LVL;

    logic [spq_pkg::KEY_W-1:0] node_reg  [1:P-1];
    logic [spq_pkg::KEY_W-1:0] node_next [1:P-1];
    logic [spq_pkg::KEY_W-1:0] full      [1:2*P-1];

    genvar g;
    generate
        for (g = 1; g < P; g++)
        begin : g_inner
            assign full[g] = node_reg[g];
            assign node_next[g] = (full[2*g+1] < full[2*g]) ? full[2*g+1] : full[2*g];
        end
        for (g = 0; g < P; g++)
        begin : g_leaf
            if (g < DEPTH)
            begin : g_used
                assign full[P+g] = leaf[g];
            end
            else
            begin : g_pad
                assign full[P+g] = {spq_pkg::KEY_W{1'b1}};
            end
        end
    endgenerate

    // one level per cycle; root settles once the leaves have passed through every registered level
    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
    end

    assign root = node_reg[1];

endmodule

/* verif/tb.sv */
module tb;

    localparam int DEPTH       = spq_pkg::DEPTH_DEF;
    localparam int LATENCY     = $clog2(DEPTH) + 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 180;

    localparam int CMD_W     = spq_pkg::CMD_W;
    localparam int ID_W      = spq_pkg::ID_W;
    localparam int TIME_W    = spq_pkg::TIME_W;
    localparam int WAIT_W    = spq_pkg::WAIT_W;
    localparam int DELTA_W   = spq_pkg::DELTA_W;
    localparam int CNT_OUT_W = spq_pkg::CNT_OUT_W;

    localparam logic [CMD_W-1:0]   CMD_FIRST_UNUSED = 3'd5;
    localparam logic [CMD_W-1:0]   CMD_LAST_CODE    = 3'd7;
    localparam logic [WAIT_W-1:0]  WAIT_MAX         = '1;
    localparam logic [TIME_W-1:0]  TIME_MAX         = '1;
    localparam logic [ID_W-1:0]    ID_MAX           = '1;
    localparam logic [DELTA_W-1:0] DELTA_MAX        = '1;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    spq_pkg::in_word_t             cmd;
    logic                          done;
    spq_pkg::out_word_t            result;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [spq_pkg::CFG_IDX_W-1:0] cfg_index;
    logic                          cfg_data;

    // shadow of the table and the sort registers
    spq_pkg::rec_t held [DEPTH];
    int            held_cnt;
    logic          key_by_arrival;
    logic          order_desc;

    spq_pkg::out_word_t status_due [$];
    int                 mismatches;
    int                 cycles;
    bit                 gapless;

    sorted_process_queue #(.DEPTH(DEPTH)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("** sorted_process_queue: FAILED **");
            $finish;
        end
    end

    function automatic spq_pkg::rec_t take_slot(int pos);
        spq_pkg::rec_t t;
        t = held[pos];
        for (int i = pos; i + 1 < held_cnt; i++)
            held[i] = held[i + 1];
        held_cnt--;
        return t;
    endfunction

    function automatic spq_pkg::out_word_t queue_step(spq_pkg::in_word_t w);
        spq_pkg::out_word_t r;
        spq_pkg::rec_t      t;
        int                 pos;
        int                 take;
        logic               hit;
        logic [TIME_W-1:0]  nk;
        logic [TIME_W-1:0]  k;
        logic [WAIT_W:0]    sum;
        logic [TIME_W-1:0]  lo;
        r    = '0;
        take = -1;
        case (w.command)
            spq_pkg::CMD_INSERT:
            begin
                if (held_cnt >= DEPTH)
                    r.overflow = 1'b1;
                else
                begin
                    nk  = key_by_arrival ? w.arrival : w.burst;
                    pos = held_cnt;
                    hit = 1'b0;
                    // equal keys stay ahead of the new record
                    for (int i = 0; i < held_cnt; i++)
                    begin
                        k = key_by_arrival ? held[i].arrival : held[i].burst;
                        if (!hit && (order_desc ? (k < nk) : (k > nk)))
                        begin
                            hit = 1'b1;
                            pos = i;
                        end
                    end
                    for (int i = held_cnt; i > pos; i--)
                        held[i] = held[i - 1];
                    held[pos].id      = w.proc_id;
                    held[pos].arrival = w.arrival;
                    held[pos].burst   = w.burst;
                    held[pos].waiting = w.waiting_init;
                    held_cnt++;
                end
            end
            spq_pkg::CMD_POP_HEAD:
            begin
                if (held_cnt > 0)
                    take = 0;
            end
            spq_pkg::CMD_POP_ARR:
            begin
                for (int i = 0; i < held_cnt; i++)
                    if (take < 0 && held[i].arrival == w.arrival)
                        take = i;
            end
            spq_pkg::CMD_ADD_WAIT:
            begin
                for (int i = 0; i < held_cnt; i++)
                begin
                    sum = {1'b0, held[i].waiting} + w.waiting_delta;
                    held[i].waiting = (sum > WAIT_MAX) ? WAIT_MAX : sum[WAIT_W-1:0];
                end
            end
            spq_pkg::CMD_CLEAR:
                held_cnt = 0;
            default:
                ;
        endcase
        if (take >= 0)
        begin
            t             = take_slot(take);
            r.found       = 1'b1;
            r.out_id      = t.id;
            r.out_arrival = t.arrival;
            r.out_burst   = t.burst;
            r.out_waiting = t.waiting;
        end
        lo = '0;
        for (int i = 0; i < held_cnt; i++)
            if (i == 0 || held[i].burst < lo)
                lo = held[i].burst;
        r.entry_count = CNT_OUT_W'(held_cnt);
        r.is_empty    = (held_cnt == 0);
        r.min_burst   = lo;
        return r;
    endfunction

    function automatic spq_pkg::in_word_t word_of(logic [CMD_W-1:0] code,
                                                  logic [ID_W-1:0] id,
                                                  logic [TIME_W-1:0] arr,
                                                  logic [TIME_W-1:0] bur,
                                                  logic [WAIT_W-1:0] wt,
                                                  logic [DELTA_W-1:0] dl);
        spq_pkg::in_word_t w;
        w.command       = code;
        w.proc_id       = id;
        w.arrival       = arr;
        w.burst         = bur;
        w.waiting_init  = wt;
        w.waiting_delta = dl;
        return w;
    endfunction

    function automatic spq_pkg::in_word_t random_word(int insert_pct);
        spq_pkg::in_word_t w;
        int                pick;
        w.command = spq_pkg::CMD_INSERT;
        w.proc_id = ID_W'($urandom);
        // narrow keys half the time so equal keys and arrival matches are common
        w.arrival = $urandom_range(0, 1) ? TIME_W'($urandom)
                                         : TIME_W'($urandom_range(0, 7));
        w.burst   = $urandom_range(0, 1) ? TIME_W'($urandom)
                                         : TIME_W'($urandom_range(0, 7));
        if ($urandom_range(0, 4) == 0)
            w.waiting_init = WAIT_MAX - WAIT_W'($urandom_range(0, 255));
        else
            w.waiting_init = WAIT_W'($urandom);
        w.waiting_delta = ($urandom_range(0, 3) == 0) ? DELTA_MAX : DELTA_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick >= insert_pct)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                w.command = spq_pkg::CMD_POP_HEAD;
            else if (pick < 70)
            begin
                w.command = spq_pkg::CMD_POP_ARR;
                if (held_cnt != 0 && $urandom_range(0, 3) != 0)
                    w.arrival = held[$urandom_range(0, held_cnt - 1)].arrival;
            end
            else if (pick < 92)
                w.command = spq_pkg::CMD_ADD_WAIT;
            else if (pick < 96)
                w.command = spq_pkg::CMD_CLEAR;
            else
                w.command = CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_CODE));
        end
        return w;
    endfunction

    // start stays high across back-to-back words
    task automatic send_word(input spq_pkg::in_word_t w);
        int gap;
        gap = gapless ? 0 : $urandom_range(0, 10);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= w;
        do @(posedge clk); while (busy);
        status_due.push_back(queue_step(w));
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (status_due.size() != 0 || busy)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(input spq_pkg::cfg_reg_e idx, input logic val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == spq_pkg::REG_SORT_KEY)
            key_by_arrival = val;
        else
            order_desc = val;
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        spq_pkg::out_word_t want;
        if (rst_n && done)
        begin
            if (status_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: %p", result);
            end
            else
            begin
                want = status_due.pop_front();
                if (result.found !== want.found || result.out_id !== want.out_id ||
                    result.out_arrival !== want.out_arrival ||
                    result.out_burst !== want.out_burst ||
                    result.out_waiting !== want.out_waiting ||
                    result.entry_count !== want.entry_count ||
                    result.is_empty !== want.is_empty ||
                    result.overflow !== want.overflow ||
                    result.min_burst !== want.min_burst)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch at cycle %0d", cycles);
                        $write("  exp found=%0b id=%0h arr=%0h burst=%0h wait=%0h",
                               want.found, want.out_id, want.out_arrival,
                               want.out_burst, want.out_waiting);
                        $display(" cnt=%0d empty=%0b ovf=%0b min=%0h",
                                 want.entry_count, want.is_empty,
                                 want.overflow, want.min_burst);
                        $write("  got found=%0b id=%0h arr=%0h burst=%0h wait=%0h",
                               result.found, result.out_id, result.out_arrival,
                               result.out_burst, result.out_waiting);
                        $display(" cnt=%0d empty=%0b ovf=%0b min=%0h",
                                 result.entry_count, result.is_empty,
                                 result.overflow, result.min_burst);
                    end
                end
            end
        end
    end

    task automatic test_empty_table();
        send_word(word_of(spq_pkg::CMD_POP_HEAD, ID_MAX, TIME_MAX, TIME_MAX, WAIT_MAX,
                          DELTA_MAX));
        send_word(word_of(spq_pkg::CMD_POP_ARR, '0, '0, '0, '0, '0));
        send_word(word_of(spq_pkg::CMD_ADD_WAIT, '0, '0, '0, '0, DELTA_MAX));
        send_word(word_of(CMD_FIRST_UNUSED, '0, '0, '0, '0, '0));
        send_word(word_of(CMD_LAST_CODE, ID_MAX, TIME_MAX, TIME_MAX, WAIT_MAX, DELTA_MAX));
    endtask

    task automatic test_insert_pop();
        send_word(word_of(spq_pkg::CMD_INSERT, ID_MAX, TIME_MAX, TIME_MAX, WAIT_MAX,
                          DELTA_MAX));
        send_word(word_of(spq_pkg::CMD_INSERT, '0, '0, '0, '0, '0));
        // same burst as the previous one: must land behind it
        send_word(word_of(spq_pkg::CMD_INSERT, 8'd1, 16'd0, 16'd0, WAIT_MAX - 24'd16, '0));
        send_word(word_of(spq_pkg::CMD_ADD_WAIT, '0, '0, '0, '0, DELTA_MAX));
        send_word(word_of(spq_pkg::CMD_POP_ARR, '0, 16'd0, '0, '0, '0));
        send_word(word_of(spq_pkg::CMD_POP_ARR, '0, 16'h1234, '0, '0, '0));
        send_word(word_of(spq_pkg::CMD_POP_HEAD, '0, '0, '0, '0, '0));
        send_word(word_of(spq_pkg::CMD_INSERT, 8'h5a, 16'h00ff, 16'h0f0f, 24'h123456, '0));
        send_word(word_of(spq_pkg::CMD_CLEAR, '0, '0, '0, '0, '0));
        send_word(word_of(spq_pkg::CMD_POP_HEAD, '0, '0, '0, '0, '0));
    endtask

    // held records keep their order when the rule changes
    task automatic test_key_change();
        send_word(word_of(spq_pkg::CMD_INSERT, 8'd10, 16'd9, 16'd5, 24'd0, '0));
        send_word(word_of(spq_pkg::CMD_INSERT, 8'd11, 16'd1, 16'd3, 24'd0, '0));
        write_reg(spq_pkg::REG_SORT_KEY, 1'b1);
        write_reg(spq_pkg::REG_SORT_ORDER, 1'b1);
        send_word(word_of(spq_pkg::CMD_INSERT, 8'd12, 16'd4, 16'd7, 24'd0, '0));
        send_word(word_of(spq_pkg::CMD_INSERT, 8'd13, 16'd9, 16'd2, 24'd0, '0));
        repeat (4) send_word(word_of(spq_pkg::CMD_POP_HEAD, '0, '0, '0, '0, '0));
    endtask

    task automatic test_random_mix();
        int pct;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph < 4)
            begin
                write_reg(spq_pkg::REG_SORT_KEY, ph[0]);
                write_reg(spq_pkg::REG_SORT_ORDER, ph[1]);
            end
            else
            begin
                write_reg(spq_pkg::REG_SORT_KEY, 1'($urandom));
                write_reg(spq_pkg::REG_SORT_ORDER, 1'($urandom));
            end
            pct = (ph % 4 == 0) ? 85 : (ph % 4 == 2) ? 20 : 50;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 30 == 0)
                    gapless = ($urandom_range(0, 3) == 0);
                send_word(random_word(pct));
            end
            gapless = 1'b0;
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        cmd            = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = 1'b0;
        held_cnt       = 0;
        key_by_arrival = 1'b0;
        order_desc     = 1'b0;
        mismatches     = 0;
        cycles         = 0;
        gapless        = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_insert_pop();
        test_key_change();
        test_random_mix();

        wait_idle();
        if (mismatches == 0)
            $display("** sorted_process_queue: PASSED **");
        else
            $display("** sorted_process_queue: FAILED **");
        $finish;
    end

endmodule
